@@ rtl/gb5_pkg.sv @@
// Shared types and constants of the 5x5 Gaussian blur block.
// Kernel weights, register indexes, stream codes and rounding constants.
`timescale 1ns / 1ps

package gb5_pkg;

	localparam int PIX_W     = 8;
	localparam int KSIZE     = 5;
	localparam int FW_W      = 12;
	localparam int FH_W      = 16;
	localparam int CFG_W     = 16;
	localparam int REG_IDX_W = 1;

	localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_DRAIN = 1'b1;

	localparam int FRAME_WIDTH_RST  = 640;
	localparam int FRAME_HEIGHT_RST = 480;

	localparam int ROW_SUM_W = 15;
	localparam int SUM_W     = 17;
	localparam int X_W       = 18;
	localparam int RECIP_W   = 19;
	localparam int RECIP_SHIFT = 28;
	localparam logic [X_W-1:0]     ROUND_BIAS = 18'd273;
	localparam logic [RECIP_W-1:0] RECIP      = 19'd491641;

	typedef logic [PIX_W-1:0] pix_t;

	typedef logic [5:0] weight_t;
	localparam weight_t WEIGHT [KSIZE][KSIZE] = '{
		'{6'd1, 6'd4,  6'd7,  6'd4,  6'd1},
		'{6'd4, 6'd16, 6'd26, 6'd16, 6'd4},
		'{6'd7, 6'd26, 6'd41, 6'd26, 6'd7},
		'{6'd4, 6'd16, 6'd26, 6'd16, 6'd4},
		'{6'd1, 6'd4,  6'd7,  6'd4,  6'd1}
	};

	typedef struct packed {
		pix_t pix;
		logic last;
		logic fend;
	} result_t;

endpackage

@@ rtl/gaussian_blur_5x5.sv @@
// A result passes the stage 1, 2 and 3 registers and the result queue before it is valid;
// the two extra results of a row's last column follow it, paced by ex_q. Throughput: one
// transaction per cycle while s_tready is high, set by the single window adder and reciprocal
// multiplier shared by all results. tready falls after the frame's last pixel until ex_q
// leaves 2, and while fewer than 3 of the 16 result queue slots are unreserved. arst_n clears
// control state and the size registers (640 x 480); the four line stores are not cleared.
// Depends on gb5_pkg.
`timescale 1ns / 1ps

module gaussian_blur_5x5 #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [gb5_pkg::REG_IDX_W-1:0]    cfg_index,
	input  logic [gb5_pkg::CFG_W-1:0]        cfg_data,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [7:0]                       s_tdata,   // gray_pixel[7:0]
	input  logic                             s_tuser,   // kind
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [7:0]                       m_tdata,   // blurred_pixel[7:0]
	output logic                             m_tlast,
	output logic                             m_tuser    // frame_end
);
	import gb5_pkg::*;

	localparam int CW      = $clog2(MAX_WIDTH);
	localparam int XW      = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
	localparam int FIFO_D  = 16;
	localparam int FIFO_AW = 4;
	localparam int OCC_W   = 5;
	localparam int W_RST   = (FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RST;
	localparam logic [CW-1:0]   WM1_RST = CW'(W_RST - 1);
	localparam logic [FH_W-1:0] HM1_RST = FH_W'(FRAME_HEIGHT_RST - 1);

	// configuration and position state
	logic [CW-1:0]   wm1_q;
	logic [FH_W-1:0] hm1_q;
	logic [CW-1:0]   in_col_q;
	logic [FH_W-1:0] in_row_q;
	logic            frame_done_q;
	logic [CW-1:0]   dcol_q;
	logic            dhalf_q;
	logic            ddone_q;

	logic [XW-1:0]   fw_x;
	logic [XW-1:0]   wcl;
	logic [CW-1:0]   wm1_nx;
	logic [FH_W-1:0] hm1_nx;

	// stage 0
	logic            s_hs;
	logic            pix_go;
	logic            drn_go;
	logic [CW-1:0]   c_eff;
	logic            at_lastcol;
	logic            at_lastrow;
	logic            emit0;
	logic [OCC_W-1:0] n_new;
	logic [CW:0]     dnext;
	logic [CW-1:0]   daddr;
	logic [CW-1:0]   rd_addr;
	logic [1:0]      bsel0 [4];
	logic            useg0 [4];

	// stage 1
	logic            pix_s1;
	logic            emit_s1;
	logic            drn_s1;
	pix_t            g_s1;
	logic            c0_s1;
	logic            c1_s1;
	logic            lastcol_s1;
	logic            lastrow_s1;
	logic [1:0]      bsel_s1 [4];
	logic            useg_s1 [4];
	logic            dcol0_s1;
	logic            dhalf_s1;
	logic            dfinal_s1;
	pix_t            rd_data [4];

	logic [1:0]      ex_q;
	pix_t            pwin_q  [KSIZE][KSIZE];
	pix_t            pwin_nx [KSIZE][KSIZE];
	pix_t            xwin_q  [KSIZE][KSIZE];
	pix_t            dwin_q  [KSIZE][4];
	pix_t            dwin_nx [KSIZE][4];
	pix_t            e0_q [4];
	pix_t            e1_q [4];
	pix_t            colv [KSIZE];
	logic [1:0]      dsel [4];
	pix_t            ewin [KSIZE][KSIZE];
	logic            job_v;
	logic            job_last;
	logic            job_fend;
	logic [ROW_SUM_W-1:0] rsum [KSIZE];

	// stages 2 and 3
	logic            v_s2;
	logic [ROW_SUM_W-1:0] rs_s2 [KSIZE];
	logic            last_s2;
	logic            fend_s2;
	logic [SUM_W-1:0] sum5;
	logic            v_s3;
	logic [X_W-1:0]  x_s3;
	logic            last_s3;
	logic            fend_s3;
	logic [X_W+RECIP_W-1:0] prod;
	result_t         res_nx;

	// result queue
	result_t         fifo_q [FIFO_D];
	logic [FIFO_AW-1:0] wptr_q;
	logic [FIFO_AW-1:0] rptr_q;
	logic [FIFO_AW:0]   cnt_q;
	logic [OCC_W-1:0]   occ_q;
	logic            m_hs;

	always_comb begin
		fw_x = XW'(cfg_data[FW_W-1:0]);
		if (fw_x < XW'(3))
			wcl = XW'(3);
		else if (fw_x > XW'(MAX_WIDTH))
			wcl = XW'(MAX_WIDTH);
		else
			wcl = fw_x;
		wm1_nx = CW'(wcl - XW'(1));
		if (cfg_data[FH_W-1:0] < FH_W'(3))
			hm1_nx = FH_W'(2);
		else
			hm1_nx = cfg_data[FH_W-1:0] - FH_W'(1);
	end

	assign s_tready = (occ_q <= OCC_W'(FIFO_D - 3)) &&
		!(frame_done_q && ((emit_s1 && lastcol_s1) || ex_q == 2'd2));
	assign s_hs   = s_tvalid && s_tready;
	assign pix_go = s_hs && s_tuser == KIND_PIXEL && !frame_done_q;
	assign drn_go = s_hs && s_tuser == KIND_DRAIN && frame_done_q && !ddone_q;

	always_comb begin
		c_eff      = (in_col_q > wm1_q) ? wm1_q : in_col_q;
		at_lastcol = c_eff == wm1_q;
		at_lastrow = in_row_q >= hm1_q;
		emit0      = pix_go && (|in_row_q[FH_W-1:1]) && (|c_eff[CW-1:1]);
		if (emit0)
			n_new = at_lastcol ? OCC_W'(3) : OCC_W'(1);
		else if (drn_go)
			n_new = OCC_W'(1);
		else
			n_new = '0;
		dnext   = {1'b0, dcol_q} + (CW+1)'(2);
		daddr   = (dnext > {1'b0, wm1_q}) ? wm1_q : dnext[CW-1:0];
		rd_addr = (s_tuser == KIND_DRAIN) ? daddr : c_eff;
		for (int k = 0; k < 4; k++) begin
			if (in_row_q < FH_W'(4 - k)) begin
				bsel0[k] = 2'd0;
				useg0[k] = in_row_q == '0;
			end else begin
				bsel0[k] = in_row_q[1:0] + 2'(k);
				useg0[k] = 1'b0;
			end
		end
	end

	for (genvar b = 0; b < 4; b++) begin : g_bank
		pix_t line_mem [MAX_WIDTH];
		pix_t rd_s1;
		always_ff @(posedge clk) begin
			rd_s1 <= line_mem[rd_addr];
			if (pix_go && in_row_q[1:0] == 2'(b))
				line_mem[c_eff] <= s_tdata;
		end
		assign rd_data[b] = rd_s1;
	end

	always_comb begin
		for (int k = 0; k < 4; k++)
			colv[k] = useg_s1[k] ? g_s1 : rd_data[bsel_s1[k]];
		colv[4] = g_s1;
		for (int k = 0; k < KSIZE; k++) begin
			for (int j = 0; j < KSIZE; j++) begin
				if (c0_s1 || j == KSIZE - 1)
					pwin_nx[k][j] = colv[k];
				else
					pwin_nx[k][j] = pwin_q[k][j+1];
			end
		end
		dsel[3] = hm1_q[1:0];
		dsel[2] = hm1_q[1:0] - 2'd1;
		dsel[1] = hm1_q[1:0] - 2'd2;
		dsel[0] = (hm1_q >= FH_W'(3)) ? hm1_q[1:0] - 2'd3 : 2'd0;
		for (int i = 0; i < 4; i++) begin
			dwin_nx[4][i] = rd_data[dsel[i]];
			for (int j = 0; j < 4; j++) begin
				if (!dcol0_s1)
					dwin_nx[j][i] = dwin_q[j+1][i];
				else if (j == 3)
					dwin_nx[j][i] = e1_q[i];
				else
					dwin_nx[j][i] = e0_q[i];
			end
		end
	end

	always_comb begin
		int jj;
		int kk;
		int sh;
		jj       = 0;
		kk       = 0;
		job_v    = 1'b0;
		job_last = 1'b0;
		job_fend = 1'b0;
		sh       = (ex_q == 2'd2) ? 1 : 2;
		for (int k = 0; k < KSIZE; k++)
			for (int j = 0; j < KSIZE; j++)
				ewin[k][j] = pwin_nx[k][j];
		if (ex_q != 2'd0) begin
			job_v    = 1'b1;
			job_last = ex_q == 2'd1;
			for (int k = 0; k < KSIZE; k++) begin
				for (int j = 0; j < KSIZE; j++) begin
					jj = j + sh;
					if (jj > KSIZE - 1)
						jj = KSIZE - 1;
					ewin[k][j] = xwin_q[k][jj];
				end
			end
		end else if (emit_s1) begin
			job_v    = 1'b1;
			job_last = !lastcol_s1;
		end else if (drn_s1) begin
			job_v    = 1'b1;
			job_last = 1'b1;
			job_fend = dfinal_s1;
			for (int k = 0; k < KSIZE; k++) begin
				for (int j = 0; j < KSIZE; j++) begin
					kk = k + (dhalf_s1 ? 1 : 0);
					if (kk > 3)
						kk = 3;
					ewin[k][j] = dwin_nx[j][kk];
				end
			end
		end
		for (int k = 0; k < KSIZE; k++) begin
			rsum[k] = '0;
			for (int j = 0; j < KSIZE; j++)
				rsum[k] = rsum[k] + ROW_SUM_W'(WEIGHT[k][j]) * ROW_SUM_W'(ewin[k][j]);
		end
	end

	always_comb begin
		sum5 = '0;
		for (int k = 0; k < KSIZE; k++)
			sum5 = sum5 + SUM_W'(rs_s2[k]);
		prod       = (X_W+RECIP_W)'(x_s3) * (X_W+RECIP_W)'(RECIP);
		res_nx.pix  = prod[RECIP_SHIFT+PIX_W-1:RECIP_SHIFT];
		res_nx.last = last_s3;
		res_nx.fend = fend_s3;
	end

	assign m_hs     = m_tvalid && m_tready;
	assign m_tvalid = cnt_q != '0;
	assign m_tdata  = fifo_q[rptr_q].pix;
	assign m_tlast  = fifo_q[rptr_q].last;
	assign m_tuser  = fifo_q[rptr_q].fend;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wm1_q        <= WM1_RST;
			hm1_q        <= HM1_RST;
			in_col_q     <= '0;
			in_row_q     <= '0;
			frame_done_q <= 1'b0;
			dcol_q       <= '0;
			dhalf_q      <= 1'b0;
			ddone_q      <= 1'b0;
			pix_s1       <= 1'b0;
			emit_s1      <= 1'b0;
			drn_s1       <= 1'b0;
			ex_q         <= '0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
			wptr_q       <= '0;
			rptr_q       <= '0;
			cnt_q        <= '0;
			occ_q        <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_FRAME_WIDTH:  wm1_q <= wm1_nx;
					REG_FRAME_HEIGHT: hm1_q <= hm1_nx;
					default: ;
				endcase
				in_col_q     <= '0;
				in_row_q     <= '0;
				frame_done_q <= 1'b0;
				dcol_q       <= '0;
				dhalf_q      <= 1'b0;
				ddone_q      <= 1'b0;
			end else begin
				if (pix_go) begin
					if (at_lastcol) begin
						in_col_q <= '0;
						if (at_lastrow) begin
							frame_done_q <= 1'b1;
							dcol_q       <= '0;
							dhalf_q      <= 1'b0;
							ddone_q      <= 1'b0;
						end else begin
							in_row_q <= in_row_q + FH_W'(1);
						end
					end else begin
						in_col_q <= c_eff + CW'(1);
					end
				end
				if (drn_go) begin
					if (dcol_q == wm1_q) begin
						dcol_q <= '0;
						if (dhalf_q)
							ddone_q <= 1'b1;
						else
							dhalf_q <= 1'b1;
					end else begin
						dcol_q <= dcol_q + CW'(1);
					end
				end
			end
			pix_s1  <= pix_go;
			emit_s1 <= emit0;
			drn_s1  <= drn_go;
			if (ex_q != 2'd0)
				ex_q <= ex_q - 2'd1;
			else if (emit_s1 && lastcol_s1)
				ex_q <= 2'd2;
			v_s2 <= job_v;
			v_s3 <= v_s2;
			if (v_s3)
				wptr_q <= wptr_q + FIFO_AW'(1);
			if (m_hs)
				rptr_q <= rptr_q + FIFO_AW'(1);
			cnt_q <= cnt_q + (FIFO_AW+1)'(v_s3) - (FIFO_AW+1)'(m_hs);
			occ_q <= occ_q + n_new - OCC_W'(m_hs);
		end
	end

	always_ff @(posedge clk) begin
		g_s1       <= s_tdata;
		c0_s1      <= c_eff == '0;
		c1_s1      <= c_eff == CW'(1);
		lastcol_s1 <= at_lastcol;
		lastrow_s1 <= at_lastrow;
		bsel_s1    <= bsel0;
		useg_s1    <= useg0;
		dcol0_s1   <= dcol_q == '0;
		dhalf_s1   <= dhalf_q;
		dfinal_s1  <= dhalf_q && dcol_q == wm1_q;
		if (pix_s1)
			pwin_q <= pwin_nx;
		if (emit_s1 && lastcol_s1)
			xwin_q <= pwin_nx;
		if (drn_s1)
			dwin_q <= dwin_nx;
		if (pix_s1 && lastrow_s1 && c0_s1)
			for (int i = 0; i < 4; i++)
				e0_q[i] <= colv[i+1];
		if (pix_s1 && lastrow_s1 && c1_s1)
			for (int i = 0; i < 4; i++)
				e1_q[i] <= colv[i+1];
		rs_s2   <= rsum;
		last_s2 <= job_last;
		fend_s2 <= job_fend;
		x_s3    <= {sum5, 1'b0} + ROUND_BIAS;
		last_s3 <= last_s2;
		fend_s3 <= fend_s2;
		if (v_s3)
			fifo_q[wptr_q] <= res_nx;
	end

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the 5x5 Gaussian blur stream block.
// Predicts every blurred pixel from its own line stores and tap window; drives bursty
// traffic with a stalling sink. Depends on gb5_pkg and gaussian_blur_5x5.
`timescale 1ns / 1ps

module tb;
	import gb5_pkg::*;

	localparam int MAXW       = 2048;
	localparam int IDLE_LIMIT = 5000;

	typedef struct packed {
		logic kind;
		pix_t gray;
	} pix_item_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic             s_tvalid;
	logic             s_tready;
	logic [7:0]       s_tdata;
	logic             s_tuser;
	logic             m_tvalid;
	logic             m_tready;
	logic [7:0]       m_tdata;
	logic             m_tlast;
	logic             m_tuser;

	gaussian_blur_5x5 u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

	localparam int KW [5][5] = '{
		'{1, 4, 7, 4, 1}, '{4, 16, 26, 16, 4}, '{7, 26, 41, 26, 7},
		'{4, 16, 26, 16, 4}, '{1, 4, 7, 4, 1}};

	pix_item_t   pixel_q[$];
	result_t     blurred_q[$];
	int          errors;
	int          idle_cycles;

	// predictor state
	pix_t        lines [4][MAXW];
	pix_t        win [5][5];
	logic [11:0] width_reg;
	logic [15:0] height_reg;
	int          col_pos, row_pos, drained;
	bit          frame_over;

	function automatic int clampi(int v, int lo, int hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic pix_t round_px(int s);
		return pix_t'((2 * s + 273) / 546);
	endfunction

	function automatic int win_sum();
		int s;
		s = 0;
		for (int k = 0; k < 5; k++)
			for (int j = 0; j < 5; j++)
				s += KW[k][j] * win[k][j];
		return s;
	endfunction

	function automatic void shift_win();
		for (int k = 0; k < 5; k++)
			for (int j = 0; j < 4; j++)
				win[k][j] = win[k][j + 1];
	endfunction

	function automatic void predict_blur(logic kind, pix_t g);
		int w, h, r, c, rr, cc, s, orow, ocol, extra;
		pix_t colv [5];
		result_t res;
		w = clampi(int'(width_reg), 3, MAXW);
		h = height_reg < 3 ? 3 : int'(height_reg);
		if (kind == KIND_DRAIN) begin
			if (!frame_over || drained >= 2 * w)
				return;
			orow = h - 2 + drained / w;
			ocol = drained % w;
			drained++;
			s = 0;
			for (int k = 0; k < 5; k++) begin
				rr = clampi(orow - 2 + k, 0, h - 1);
				for (int j = 0; j < 5; j++) begin
					cc = clampi(ocol - 2 + j, 0, w - 1);
					s += KW[k][j] * lines[rr % 4][cc];
				end
			end
			res.pix = round_px(s);
			res.last = 1'b1;
			res.fend = (drained == 2 * w);
			blurred_q.push_back(res);
			return;
		end
		if (frame_over)
			return;
		r = row_pos;
		c = col_pos >= w ? w - 1 : col_pos;
		for (int k = 0; k < 5; k++) begin
			rr = r - 4 + k < 0 ? 0 : r - 4 + k;
			colv[k] = (rr == r) ? g : lines[rr % 4][c];
		end
		lines[r % 4][c] = g;
		if (c == 0) begin
			for (int k = 0; k < 5; k++)
				for (int j = 0; j < 5; j++)
					win[k][j] = colv[k];
		end else begin
			shift_win();
			for (int k = 0; k < 5; k++)
				win[k][4] = colv[k];
		end
		if (r >= 2 && c >= 2) begin
			extra = (c == w - 1) ? 2 : 0;
			for (int e = 0; e <= extra; e++) begin
				if (e > 0)
					shift_win();
				res.pix = round_px(win_sum());
				res.last = (e == extra);
				res.fend = 1'b0;
				blurred_q.push_back(res);
			end
		end
		if (c + 1 >= w) begin
			col_pos = 0;
			if (r + 1 >= h) begin
				frame_over = 1'b1;
				drained = 0;
			end else begin
				row_pos = r + 1;
			end
		end else begin
			col_pos = c + 1;
		end
	endfunction

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// driver: bursts of random length, random gaps
	int burst_left, gap_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
			burst_left = 4;
			gap_left = 0;
		end else if (!s_tvalid || s_tready) begin
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (pixel_q.size() > 0) begin
				pix_item_t it;
				it = pixel_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= it.gray;
				s_tuser <= it.kind;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// sink stall pattern: one of four ready modes, redrawn at random
	int ready_mode, ready_tick;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			ready_mode = 0;
			ready_tick = 0;
		end else begin
			ready_tick++;
			if (ready_tick % 64 == 0)
				ready_mode = $urandom_range(0, 3);
			case (ready_mode)
				0: begin
					m_tready <= 1'b1;
				end
				1: begin
					m_tready <= ($urandom_range(0, 9) < 7);
				end
				2: begin
					m_tready <= (ready_tick % 4 == 0);
				end
				default: begin
					m_tready <= ($urandom_range(0, 9) < 2);
				end
			endcase
		end
	end

	// monitor: check results, then predict from accepted transactions
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (blurred_q.size() == 0) begin
					$display("%0t: unexpected result pix=%0d last=%0b fend=%0b",
						$time, m_tdata, m_tlast, m_tuser);
					errors++;
				end else begin
					result_t want;
					want = blurred_q.pop_front();
					if (want.pix !== m_tdata || want.last !== m_tlast
						|| want.fend !== m_tuser) begin
						$display("%0t: expected pix=%0d last=%0b fend=%0b, got pix=%0d last=%0b fend=%0b",
							$time, want.pix, want.last, want.fend, m_tdata, m_tlast, m_tuser);
						errors++;
					end
				end
			end
			if (s_tvalid && s_tready)
				predict_blur(s_tuser, s_tdata);
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || cfg_we)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	task automatic add_item(logic kind, pix_t g);
		pix_item_t it;
		it.kind = kind;
		it.gray = g;
		pixel_q.push_back(it);
	endtask

	task automatic wait_drained();
		while (pixel_q.size() != 0 || s_tvalid || blurred_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_FRAME_WIDTH)
			width_reg = val[11:0];
		else
			height_reg = val;
		col_pos = 0;
		row_pos = 0;
		drained = 0;
		frame_over = 1'b0;
	endtask

	// push a frame; a broken frame is cut short, noise adds stray drains and trailing pixels
	task automatic add_frame(int w, int h, bit broken, bit noise, output int n);
		int total;
		total = broken ? $urandom_range(1, w * h) : w * h;
		n = 0;
		for (int i = 0; i < total; i++) begin
			if (noise && $urandom_range(0, 15) == 0) begin
				add_item(KIND_DRAIN, pix_t'($urandom));
				n++;
			end
			add_item(KIND_PIXEL, pix_t'($urandom));
			n++;
		end
		if (!broken) begin
			for (int i = 0; i < 2 * w; i++) begin
				if (noise && $urandom_range(0, 5) == 0) begin
					add_item(KIND_PIXEL, pix_t'($urandom));
					n++;
				end
				add_item(KIND_DRAIN, pix_t'($urandom));
				n++;
			end
			if (noise) begin
				add_item(KIND_DRAIN, 8'hFF);
				n++;
			end
		end
	endtask

	initial begin
		int n, sent, w, h;
		errors = 0;
		idle_cycles = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_FRAME_WIDTH;
		cfg_data = '0;
		width_reg = 12'(FRAME_WIDTH_RST);
		height_reg = 16'(FRAME_HEIGHT_RST);
		col_pos = 0;
		row_pos = 0;
		drained = 0;
		frame_over = 1'b0;
		for (int k = 0; k < 5; k++)
			for (int j = 0; j < 5; j++)
				win[k][j] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: 3x3 frame via clamped sizes, extremes, early and late drains
		write_reg(REG_FRAME_WIDTH, 16'hF002);
		write_reg(REG_FRAME_HEIGHT, 16'h0000);
		add_item(KIND_DRAIN, 8'h00);
		add_item(KIND_PIXEL, 8'hFF);
		add_item(KIND_PIXEL, 8'h00);
		add_item(KIND_PIXEL, 8'hFF);
		add_item(KIND_PIXEL, 8'h00);
		add_item(KIND_DRAIN, 8'hAA);
		add_item(KIND_PIXEL, 8'hFF);
		add_item(KIND_PIXEL, 8'h80);
		add_item(KIND_PIXEL, 8'h7F);
		add_item(KIND_PIXEL, 8'h01);
		add_item(KIND_PIXEL, 8'hFE);
		add_item(KIND_PIXEL, 8'h55);
		for (int i = 0; i < 6; i++)
			add_item(KIND_DRAIN, 8'h00);
		add_item(KIND_DRAIN, 8'hFF);
		add_item(KIND_DRAIN, 8'h00);
		add_item(KIND_PIXEL, 8'h12);

		// width above the maximum, start of the first row only
		write_reg(REG_FRAME_WIDTH, 16'h0FFF);
		for (int i = 0; i < 16; i++)
			add_item(KIND_PIXEL, pix_t'($urandom));

		// tallest height, partial frame only
		write_reg(REG_FRAME_WIDTH, 16'd5);
		write_reg(REG_FRAME_HEIGHT, 16'hFFFF);
		add_frame(5, 12, 1'b1, 1'b1, n);

		// random frames of small sizes
		sent = 0;
		while (sent < 120) begin
			w = $urandom_range(0, 12);
			h = $urandom_range(0, 7);
			write_reg(REG_FRAME_WIDTH, CFG_W'(w));
			write_reg(REG_FRAME_HEIGHT, CFG_W'(h));
			add_frame(w < 3 ? 3 : w, h < 3 ? 3 : h, $urandom_range(0, 7) == 0,
				$urandom_range(0, 2) == 0, n);
			sent += n;
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (blurred_q.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, blurred_q.size());
			errors++;
		end
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

@@ gaussian_blur_5x5.f @@
rtl/gb5_pkg.sv
rtl/gaussian_blur_5x5.sv
tb/tb.sv
